// ----- rtl/assert_macros.svh -----
// ------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, disabled while rst is high
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implies");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/rkst_pkg.sv -----
// ------------------------------------------------------------------------
// rkst_pkg
// shared constants and types of the range k-th smallest tree unit
// ------------------------------------------------------------------------
package rkst_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 10;
  localparam int NODE_SLOTS = 16384;

  localparam int NODE_AW   = $clog2(NODE_SLOTS);
  localparam int FREE_W    = $clog2(NODE_SLOTS + 1);
  localparam int VER_DEPTH = MAX_ITEMS + 1;
  localparam int VER_AW    = $clog2(VER_DEPTH);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int POS_W     = 11;
  localparam int RANK_W    = 11;
  localparam int LVL_W     = $clog2(VALUE_BITS + 1);

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic [CNT_W-1:0]   count;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_BAD_RANK  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    FN_APPEND = 1'b0,
    FN_QUERY  = 1'b1
  } func_t;

  // one accepted item, already checked
  typedef struct packed {
    func_t              func;
    status_t            status;
    logic [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]   range_start;
    logic [POS_W-1:0]   range_end;
    logic [RANK_W-1:0]  rank;
  } cmd_t;

  // engine state seen by the front end
  typedef struct packed {
    logic             idle;
    logic             full;
    logic [CNT_W-1:0] elem_count;
  } eng_stat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] answer;
    status_t               status;
  } result_t;

endpackage

// ----- rtl/range_kth_smallest_persistent_tree_unit.sv -----
// ------------------------------------------------------------------------
// range_kth_smallest_persistent_tree_unit
// persistent count tree over a 10-bit value domain, range k-th smallest
// ------------------------------------------------------------------------
// One item at a time. An append copies the root-to-leaf path of the newest
// version into fresh node slots, one node per cycle. A query walks the two
// versions that bound the range side by side: each level reads both left
// children (states QLEFT and QCMP), and a step to the right reads both right
// children as well and reloads them (state QLOAD), so a query takes longer
// the more answer bits are one. The walk is paced by the registered read of
// the node memory on every tree level. Items with a bad range, a bad rank or
// no room left go straight from idle to done without touching the stores.
// The node memory and the version-root memory need no clearing pass after
// reset: slot zero of each reads as the null node, and every other slot is
// written before any walk can reach it. The next word is taken as soon as
// the engine is idle, even if the last result still waits in the output
// register.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module range_kth_smallest_persistent_tree_unit
  import rkst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // value[9:0], range_start[20:10],
                                // range_end[31:21], rank[42:32], zero fill
  input  logic        s_tuser,  // func: 0 append, 1 query
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // answer[9:0], zero fill
  output logic [1:0]  m_tuser   // status
);

  localparam int IN_START_LO = VALUE_BITS;
  localparam int IN_END_LO   = IN_START_LO + POS_W;
  localparam int IN_RANK_LO  = IN_END_LO + POS_W;

  cmd_t      cmd;
  eng_stat_t stat;
  result_t   res;
  logic      res_valid, res_ready, s_fire;
  logic [POS_W-1:0]  r_start, r_end;
  logic [RANK_W-1:0] r_rank;
  logic [POS_W:0]    span;

  assign r_start = s_tdata[IN_START_LO +: POS_W];
  assign r_end   = s_tdata[IN_END_LO +: POS_W];
  assign r_rank  = s_tdata[IN_RANK_LO +: RANK_W];

  // number of positions in the range, valid once start <= end
  assign span = {1'b0, r_end} - {1'b0, r_start} + (POS_W+1)'(1);

  assign s_tready = stat.idle;
  assign s_fire   = s_tvalid && s_tready;

  // front-end checks, bad range before bad rank
  always_comb begin
    cmd.func        = func_t'(s_tuser);
    cmd.value       = s_tdata[VALUE_BITS-1:0];
    cmd.range_start = r_start;
    cmd.range_end   = r_end;
    cmd.rank        = r_rank;
    cmd.status      = ST_OK;
    if (cmd.func == FN_APPEND) begin
      if (stat.full) begin
        cmd.status = ST_FULL;
      end
    end else begin
      if ((r_start == '0) || (r_end > POS_W'(stat.elem_count)) ||
          (r_start > r_end)) begin
        cmd.status = ST_BAD_RANGE;
      end else if ((r_rank == '0) || ({1'b0, r_rank} > span)) begin
        cmd.status = ST_BAD_RANK;
      end
    end
  end

  rkst_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, refilled when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {(16 - VALUE_BITS)'(0), res.answer};
      m_tuser <= res.status;
    end
  end

  // element count never passes the version capacity
  `ASSERT_ALWAYS(a_count_bound, stat.elem_count <= CNT_W'(MAX_ITEMS))
  // a rejected item is answered in the very next cycle
  `ASSERT_NEXT(a_err_fast, s_fire && (cmd.status != ST_OK), res_valid)
  // no new word while a result is still held in the engine
  `ASSERT_IMPLIES(a_no_overlap, s_fire, !res_valid)
  // the output register is only loaded when it is free
  `ASSERT_NEXT(a_no_overwrite, m_tvalid && !m_tready && res_valid,
               m_tvalid && $stable(m_tdata))

endmodule

// ----- rtl/rkst_ram.sv -----
// ------------------------------------------------------------------------
// rkst_ram
// generic ram, one write port, two read ports with registered data
// ------------------------------------------------------------------------
module rkst_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/rkst_walk.sv -----
// ------------------------------------------------------------------------
// rkst_walk
// tree engine: path copy for appends, paired descent for queries
// ------------------------------------------------------------------------
module rkst_walk
  import rkst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output eng_stat_t stat,
  output logic      res_valid,
  input  logic      res_ready,
  output result_t   res
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_AROOT = 8'b0000_0010,
    S_ALVL  = 8'b0000_0100,
    S_QROOT = 8'b0000_1000,
    S_QLOAD = 8'b0001_0000,
    S_QLEFT = 8'b0010_0000,
    S_QCMP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      elem_count, elem_count_next;
  logic [FREE_W-1:0]     next_free, next_free_next;
  logic [LVL_W-1:0]      lvl, lvl_next;
  logic [VALUE_BITS-1:0] value, value_next;
  logic [RANK_W-1:0]     k, k_next;
  logic [VALUE_BITS-1:0] ans, ans_next;
  status_t               rstat, rstat_next;
  node_t                 a_node, a_node_next, b_node, b_node_next;
  logic                  za, zb, vza, vzb;

  // memory ports
  logic                  node_we;
  logic [NODE_AW-1:0]    node_waddr, node_raddr_a, node_raddr_b;
  node_t                 node_wdata;
  logic [NODE_W-1:0]     node_rdata_a, node_rdata_b;
  logic                  ver_we;
  logic [VER_AW-1:0]     ver_waddr, ver_raddr_a, ver_raddr_b;
  logic [NODE_AW-1:0]    ver_wdata, ver_rdata_a, ver_rdata_b;

  node_t                 node_a, node_b;
  logic [NODE_AW-1:0]    ver_a, ver_b;
  logic                  start, dir_bit;
  logic [CNT_W-1:0]      cdiff;
  logic [VALUE_BITS-1:0] vshift;

  rkst_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .raddr_a (node_raddr_a),
    .rdata_a (node_rdata_a),
    .raddr_b (node_raddr_b),
    .rdata_b (node_rdata_b)
  );

  rkst_ram #(.WIDTH(NODE_AW), .DEPTH(VER_DEPTH)) u_ver_ram (
    .clk     (clk),
    .we      (ver_we),
    .waddr   (ver_waddr),
    .wdata   (ver_wdata),
    .raddr_a (ver_raddr_a),
    .rdata_a (ver_rdata_a),
    .raddr_b (ver_raddr_b),
    .rdata_b (ver_rdata_b)
  );

  // entry zero of both stores is null and never written
  assign node_a = za ? '0 : node_t'(node_rdata_a);
  assign node_b = zb ? '0 : node_t'(node_rdata_b);
  assign ver_a  = vza ? '0 : ver_rdata_a;
  assign ver_b  = vzb ? '0 : ver_rdata_b;

  assign start   = (state == S_IDLE) && cmd_valid;
  assign vshift  = value >> (lvl - LVL_W'(1));
  assign dir_bit = vshift[0];
  assign cdiff   = node_a.count - node_b.count;

  assign ver_raddr_a = (cmd.func == FN_QUERY) ? cmd.range_end[VER_AW-1:0]
                                              : elem_count[VER_AW-1:0];
  assign ver_raddr_b = VER_AW'(cmd.range_start - POS_W'(1));
  assign ver_we      = start && (cmd.func == FN_APPEND) && (cmd.status == ST_OK);
  assign ver_waddr   = VER_AW'(elem_count) + VER_AW'(1);
  assign ver_wdata   = next_free[NODE_AW-1:0];

  assign stat.idle       = (state == S_IDLE);
  assign stat.elem_count = elem_count;
  assign stat.full       = (elem_count >= CNT_W'(MAX_ITEMS)) ||
                           (({1'b0, next_free} + (FREE_W+1)'(VALUE_BITS + 1)) >
                            (FREE_W+1)'(NODE_SLOTS));

  assign res_valid  = (state == S_DONE);
  assign res.answer = ans;
  assign res.status = rstat;

  always_comb begin
    state_next      = state;
    elem_count_next = elem_count;
    next_free_next  = next_free;
    lvl_next        = lvl;
    value_next      = value;
    k_next          = k;
    ans_next        = ans;
    rstat_next      = rstat;
    a_node_next     = a_node;
    b_node_next     = b_node;
    node_we         = 1'b0;
    node_waddr      = next_free[NODE_AW-1:0];
    node_wdata      = '0;
    node_raddr_a    = '0;
    node_raddr_b    = '0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          rstat_next = cmd.status;
          ans_next   = '0;
          value_next = cmd.value;
          k_next     = cmd.rank;
          lvl_next   = LVL_W'(VALUE_BITS);
          if (cmd.status != ST_OK) begin
            state_next = S_DONE;
          end else if (cmd.func == FN_APPEND) begin
            state_next = S_AROOT;
          end else begin
            state_next = S_QROOT;
          end
        end
      end
      S_AROOT: begin
        node_raddr_a = ver_a;
        state_next   = S_ALVL;
      end
      S_ALVL: begin
        // copy of the old path node, count raised by one
        node_we          = 1'b1;
        node_wdata       = node_a;
        node_wdata.count = node_a.count + CNT_W'(1);
        next_free_next   = next_free + FREE_W'(1);
        if (lvl == '0) begin
          node_wdata.left  = '0;
          node_wdata.right = '0;
          elem_count_next  = elem_count + CNT_W'(1);
          state_next       = S_DONE;
        end else begin
          if (dir_bit) begin
            node_wdata.right = next_free_next[NODE_AW-1:0];
            node_raddr_a     = node_a.right;
          end else begin
            node_wdata.left = next_free_next[NODE_AW-1:0];
            node_raddr_a    = node_a.left;
          end
          lvl_next = lvl - LVL_W'(1);
        end
      end
      S_QROOT: begin
        node_raddr_a = ver_a;
        node_raddr_b = ver_b;
        state_next   = S_QLOAD;
      end
      S_QLOAD: begin
        a_node_next = node_a;
        b_node_next = node_b;
        state_next  = S_QLEFT;
      end
      S_QLEFT: begin
        node_raddr_a = a_node.left;
        node_raddr_b = b_node.left;
        state_next   = S_QCMP;
      end
      S_QCMP: begin
        lvl_next = lvl - LVL_W'(1);
        if (k <= cdiff) begin
          a_node_next = node_a;
          b_node_next = node_b;
          state_next  = (lvl == LVL_W'(1)) ? S_DONE : S_QLEFT;
        end else begin
          k_next       = k - RANK_W'(cdiff);
          ans_next     = ans | (VALUE_BITS'(1) << (lvl - LVL_W'(1)));
          node_raddr_a = a_node.right;
          node_raddr_b = b_node.right;
          state_next   = (lvl == LVL_W'(1)) ? S_DONE : S_QLOAD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      next_free  <= FREE_W'(1);
      za         <= 1'b1;
      zb         <= 1'b1;
      vza        <= 1'b1;
      vzb        <= 1'b1;
    end else begin
      state      <= state_next;
      elem_count <= elem_count_next;
      next_free  <= next_free_next;
      za         <= (node_raddr_a == '0);
      zb         <= (node_raddr_b == '0);
      vza        <= (ver_raddr_a == '0);
      vzb        <= (ver_raddr_b == '0);
    end
  end

  always_ff @(posedge clk) begin
    lvl    <= lvl_next;
    value  <= value_next;
    k      <= k_next;
    ans    <= ans_next;
    rstat  <= rstat_next;
    a_node <= a_node_next;
    b_node <= b_node_next;
  end

endmodule

// ----- tb/sv/kth_smallest_checker.sv -----
// ------------------------------------------------------------------------
// kth_smallest_checker
// watches both stream channels, predicts every result word and compares
// ------------------------------------------------------------------------
// keeps its own persistent count tree, built the same way as the block's:
// one fresh path per append, two side-by-side walks per query
// ------------------------------------------------------------------------
module kth_smallest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,  // value[9:0], range_start[20:10],
                                // range_end[31:21], rank[42:32], zero fill
  input  logic        s_tuser,  // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // answer[9:0], zero fill
  input  logic [1:0]  m_tuser,  // status
  output int          mismatches,
  output int          outstanding,
  output int          n_results,
  output int          n_answered,
  output int          n_flagged
);
  timeunit 1ns;
  timeprecision 1ps;
  import rkst_pkg::*;

  // predicted tree: children and counts per node, root per version
  int unsigned left_of  [NODE_SLOTS];
  int unsigned right_of [NODE_SLOTS];
  int unsigned tally    [NODE_SLOTS];
  int unsigned root_of  [MAX_ITEMS+1];
  int unsigned seq_len;
  int unsigned free_slot;

  result_t pending_results[$];

  task automatic clear_tree();
    foreach (left_of[i]) begin
      left_of[i]  = 0;
      right_of[i] = 0;
      tally[i]    = 0;
    end
    foreach (root_of[i]) root_of[i] = 0;
    seq_len   = 0;
    free_slot = 1;
  endtask

  // copy the newest version's root-to-leaf path, one count higher
  function automatic status_t append_path(int unsigned v);
    int unsigned prev, cur, nxt, sub;
    if (seq_len >= MAX_ITEMS || free_slot + VALUE_BITS + 1 > NODE_SLOTS)
      return ST_FULL;
    prev = root_of[seq_len];
    cur  = free_slot;
    free_slot++;
    root_of[seq_len + 1] = cur;
    for (int lvl = VALUE_BITS; lvl >= 1; lvl--) begin
      nxt = free_slot;
      free_slot++;
      left_of[cur]  = left_of[prev];
      right_of[cur] = right_of[prev];
      tally[cur]    = tally[prev] + 1;
      if (((v >> (lvl - 1)) & 1) != 0) begin
        sub           = right_of[prev];
        right_of[cur] = nxt;
      end else begin
        sub          = left_of[prev];
        left_of[cur] = nxt;
      end
      prev = sub;
      cur  = nxt;
    end
    left_of[cur]  = 0;
    right_of[cur] = 0;
    tally[cur]    = tally[prev] + 1;
    seq_len++;
    return ST_OK;
  endfunction

  // walk versions e and s-1 together, steering by left-count differences
  function automatic result_t kth_in_range(int unsigned s, int unsigned e,
                                           int unsigned k);
    result_t     r;
    int unsigned a, b, c;
    r.answer = '0;
    r.status = ST_OK;
    if (s == 0 || e > seq_len || s > e) begin
      r.status = ST_BAD_RANGE;
    end else if (k == 0 || k > e - s + 1) begin
      r.status = ST_BAD_RANK;
    end else begin
      a = root_of[e];
      b = root_of[s - 1];
      for (int lvl = VALUE_BITS; lvl >= 1; lvl--) begin
        c = tally[left_of[a]] - tally[left_of[b]];
        if (k <= c) begin
          a = left_of[a];
          b = left_of[b];
        end else begin
          k = k - c;
          a = right_of[a];
          b = right_of[b];
          r.answer[lvl-1] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic result_t tree_result_of(func_t fn, logic [47:0] word);
    result_t r;
    r.answer = '0;
    if (fn == FN_APPEND) r.status = append_path(word[9:0]);
    else r = kth_in_range(word[20:10], word[31:21], word[42:32]);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      clear_tree();
      pending_results.delete();
      mismatches  = 0;
      outstanding = 0;
      n_results   = 0;
      n_answered  = 0;
      n_flagged   = 0;
    end else begin
      // result side first: a word leaving now belongs to an older input
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        got.answer = m_tdata[VALUE_BITS-1:0];
        got.status = status_t'(m_tuser);
        n_results++;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result word %0d with none pending: answer %0d status %0d",
                                  n_results, got.answer, got.status));
        end else begin
          want = pending_results.pop_front();
          if (got.answer !== want.answer || got.status !== want.status)
            flag_mismatch($sformatf("result word %0d: answer exp %0d got %0d, status exp %0d got %0d",
                                    n_results, want.answer, got.answer,
                                    want.status, got.status));
        end
      end
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        want = tree_result_of(func_t'(s_tuser), s_tdata);
        if (want.status != ST_OK) n_flagged++;
        else if (s_tuser == FN_QUERY) n_answered++;
        pending_results.insert(pending_results.size(), want);
      end
      outstanding = pending_results.size();
    end
  end

endmodule

// ----- tb/sv/range_kth_smallest_persistent_tree_unit_tb.sv -----
// ------------------------------------------------------------------------
// range_kth_smallest_persistent_tree_unit_tb
// stimulus and verdict for the range k-th smallest tree unit
// ------------------------------------------------------------------------
// a short directed run over empty-sequence queries, value extremes, every
// query status code and all-ones fields, then random appends mixed with
// mostly well-formed queries, then a closing batch of queries over the
// sequence as built. the sequence stays well below its limit, so store
// full is not reached. both sides idle at random with bursts of
// back-to-back words; the checker beside the block predicts and compares
// every result word
// ------------------------------------------------------------------------
module range_kth_smallest_persistent_tree_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rkst_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 350;
  // ~400 words, each allowing for a sender gap, the longest query and a
  // receiver stall, taken several times over
  localparam int CYCLE_LIMIT  = 150_000;
  // room for the longest query; let any stray word show up
  localparam int DRAIN_CYCLES = 48;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // value[9:0], range_start[20:10],
                          // range_end[31:21], rank[42:32], zero fill
  logic        s_tuser;   // func: 0 append, 1 query
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // answer[9:0], zero fill
  logic [1:0]  m_tuser;   // status

  int mismatches;
  int outstanding;
  int n_results;
  int n_answered;
  int n_flagged;

  // stimulus bookkeeping: sequence length as the block should see it
  int n_elems;
  int n_appends;
  int n_queries;
  int cycle_count;
  bit tx_burst;
  bit rx_burst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  range_kth_smallest_persistent_tree_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  kth_smallest_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_results   (n_results),
    .n_answered  (n_answered),
    .n_flagged   (n_flagged)
  );

  // one input word; valid stays high across back-to-back words so it is
  // only lowered when a gap is drawn
  task automatic send_word(func_t fn, logic [VALUE_BITS-1:0] v,
                           logic [POS_W-1:0] rs, logic [POS_W-1:0] re,
                           logic [RANK_W-1:0] rk);
    int gap;
    if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {5'b0, rk, re, rs, v};
    do @(posedge clk); while (s_tready !== 1'b1);
    if (fn == FN_APPEND) begin
      n_appends++;
      if (n_elems < MAX_ITEMS) n_elems++;
    end else begin
      n_queries++;
    end
  endtask

  // appends carry junk in the query fields so those bits toggle too
  task automatic append_value(logic [VALUE_BITS-1:0] v);
    send_word(FN_APPEND, v, POS_W'($urandom), POS_W'($urandom), RANK_W'($urandom));
  endtask

  task automatic ask(logic [POS_W-1:0] rs, logic [POS_W-1:0] re,
                     logic [RANK_W-1:0] rk);
    send_word(FN_QUERY, VALUE_BITS'($urandom), rs, re, rk);
  endtask

  // extremes, a narrow band for many duplicates, and plain random values
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VALUE_BITS'($urandom_range(500, 515));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // range inside the current sequence, rank inside the range
  task automatic ask_valid_range();
    int e, s, k, width;
    e = $urandom_range(1, n_elems);
    s = $urandom_range(1, e);
    if ($urandom_range(0, 7) == 0) s = 1;
    width = e - s + 1;
    case ($urandom_range(0, 5))
      0:       k = 1;
      1:       k = width;
      default: k = $urandom_range(1, width);
    endcase
    ask(POS_W'(s), POS_W'(e), RANK_W'(k));
  endtask

  // broken queries: fully random fields, or a good range with a bad rank
  task automatic ask_broken();
    int e, s;
    if (n_elems == 0 || $urandom_range(0, 1) == 0) begin
      ask(POS_W'($urandom), POS_W'($urandom), RANK_W'($urandom));
    end else begin
      e = $urandom_range(1, n_elems);
      s = $urandom_range(1, e);
      if ($urandom_range(0, 2) == 0) ask(POS_W'(s), POS_W'(e), '0);
      else ask(POS_W'(s), POS_W'(e), RANK_W'(e - s + 2 + $urandom_range(0, 20)));
    end
  endtask

  // receiver: per word, an optional stall, then ready until taken
  initial begin
    int gap;
    m_tready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
    end
  end

  // cycle counter and timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles with %0d results pending",
             cycle_count, outstanding);
    $display("range_kth_smallest_persistent_tree_unit_tb: done, errors");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FN_APPEND;
    n_elems   = 0;
    n_appends = 0;
    n_queries = 0;
    tx_burst  = 1'b0;
    rx_burst  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // empty sequence: every query is a bad range
    ask(1, 1, 1);
    ask(0, 0, 0);
    // value extremes, middle, duplicate
    append_value(10'd0);
    append_value(10'd1023);
    append_value(10'd512);
    append_value(10'd1023);
    // ok answers: smallest, largest, among duplicates, single position
    ask(1, 4, 1);
    ask(1, 4, 4);
    ask(2, 4, 2);
    ask(3, 3, 1);
    ask(1, 4, 3);
    // bad range: start zero, start past end, end past sequence
    ask(0, 4, 1);
    ask(3, 2, 1);
    ask(1, 5, 1);
    // bad rank: zero and one past the range size
    ask(1, 4, 0);
    ask(1, 4, 5);
    // bad range wins over bad rank
    ask(5, 2, 0);
    // all-ones fields
    ask(11'h7ff, 11'h7ff, 11'h7ff);
    ask(1, 4, 11'h7ff);
    append_value(10'h3ff);
    ask(2, 5, 3);

    // ---- random: appends mixed with mostly well-formed queries ----
    repeat (RANDOM_ITEMS) begin
      if (n_elems == 0 || $urandom_range(0, 99) < 45) append_value(pick_value());
      else if ($urandom_range(0, 9) < 8) ask_valid_range();
      else ask_broken();
    end

    // ---- closing queries over the sequence as built ----
    repeat (30) begin
      if ($urandom_range(0, 4) == 0) ask_broken();
      else ask_valid_range();
    end
    s_tvalid <= 1'b0;

    // wait for every expected word, then a little longer for strays
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d appends and %0d queries; sequence reached %0d elements",
             n_appends, n_queries, n_elems);
    $display("checked %0d result words: %0d answered queries, %0d flagged, %0d mismatches",
             n_results, n_answered, n_flagged, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("range_kth_smallest_persistent_tree_unit_tb: done, clean");
    else
      $display("range_kth_smallest_persistent_tree_unit_tb: done, errors");
    $finish;
  end

endmodule
